// ----- design/ffha_pkg.sv -----
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;
	localparam int unsigned HEAP_BYTES = 32768;
	localparam int unsigned DEPTH = HEAP_BYTES / 8;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned OW = $clog2(HEAP_BYTES) + 2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OOM  = 2'd2;
	localparam logic [1:0] ST_IGN  = 2'd3;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic CFG_BASE = 1'b0;
	localparam logic CFG_LEN  = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [15:0] alloc_size;
		logic [31:0] free_addr;
	} req_t;

	typedef struct packed {
		logic [31:0] result_addr;
		logic [1:0]  status;
		logic [15:0] used_bytes;
	} rsp_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE,
		S_AWALK_RD, S_AWALK_CHK, S_AWR2, S_ABUMP,
		S_F_RD, S_F_CHK, S_F_NRD, S_F_NCHK, S_F_WRH,
		S_F_PRD, S_F_PCHK, S_F_PMRG, S_F_HW, S_F_HWCHK,
		S_DONE
	} state_t;
endpackage

// ----- design/first_fit_heap_allocator.sv -----
// First-fit heap allocator: header memory, walk sequencer and result register.
// An allocation walks the headers from the heap start and splits a block when the rest
// is large enough; a free walks the headers up to its block to find its predecessor.
// A zero-size request and an ignored free are answered without a walk.
// One request at a time; busy falls in the cycle that carries the result strobe.
// Reset or any register write runs a clearing pass over all DEPTH (4096) words
// of the header memory, with busy high.
// The result is shown for one cycle on done; the receiver cannot stall.
module first_fit_heap_allocator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  ffha_pkg::req_t       req,
	output logic                 busy,
	output logic                 done,
	output ffha_pkg::rsp_t       rsp,
	input  logic                 cfg_we,
	input  logic                 cfg_idx,
	input  logic [31:0]          cfg_data
);
	import ffha_pkg::*;

	logic [16:0] mem [DEPTH];
	logic [16:0] rdata;
	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic [16:0] wdata;

	state_t state_q, state_d;
	logic [31:0] base_q;
	logic [15:0] len_q;
	logic [31:0] hw_q;
	logic [15:0] used_q;
	logic [OW-1:0] off_q, hoff_q, prev_q, cur_q;
	logic        have_prev_q;
	logic [16:0] sz_q;
	logic [15:0] bsize_q;
	logic [AW:0] clr_q;
	req_t        req_q;
	rsp_t        rsp_q;
	logic        done_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

	logic [OW-1:0] len_eff, hwoff, total, btotal, rem, nxt, hoff_c;
	logic [31:0] hoff32;
	assign len_eff = (len_q < 16'(HEAP_BYTES) || HEAP_BYTES > 32768) ?
		OW'(len_q) : OW'(HEAP_BYTES);
	assign hwoff  = OW'(hw_q - base_q);
	assign total  = OW'(sz_q) + OW'(8);
	assign btotal = OW'(rdata[15:0]) + OW'(8);
	assign rem    = btotal - total;
	assign nxt    = hoff_q + OW'(8) + OW'(bsize_q);
	assign hoff32 = req_q.free_addr - 32'd8 - base_q;
	assign hoff_c = OW'(hoff32);
	logic hw_full;
	assign hw_full = (32'(hwoff) >= 32'(len_eff));

	logic [31:0] hw_d;
	logic [15:0] used_d, bsize_d;
	logic [16:0] sz_d;
	logic [OW-1:0] off_d, hoff_d, prev_d, cur_d;
	logic have_prev_d, done_d, upd_rsp;
	rsp_t rsp_d;

	always_comb begin
		state_d = state_q;
		we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
		hw_d = hw_q; used_d = used_q; sz_d = sz_q; bsize_d = bsize_q;
		off_d = off_q; hoff_d = hoff_q; prev_d = prev_q; cur_d = cur_q;
		have_prev_d = have_prev_q; done_d = 1'b0; upd_rsp = 1'b0;
		rsp_d = '{result_addr: 32'd0, status: ST_OK, used_bytes: used_q};
		case (state_q)
			S_CLEAR: begin
				we = 1'b1; waddr = clr_q[AW-1:0];
				if (clr_q == (AW+1)'(DEPTH - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					off_d = '0;
					// round up in 17 bits so the largest sizes do not wrap to zero
					sz_d = ({1'b0, req.alloc_size} + 17'd7) & ~17'd7;
					if (req.req_type == REQ_ALLOC) begin
						if (req.alloc_size == 16'd0) begin
							rsp_d.status = ST_ZERO; upd_rsp = 1'b1; state_d = S_DONE;
						end else state_d = S_AWALK_RD;
					end else state_d = S_F_RD;
				end
			end
			S_AWALK_RD: begin
				raddr = off_q[AW+2:3];
				if (off_q < hwoff && off_q < len_eff) state_d = S_AWALK_CHK;
				else state_d = S_ABUMP;
			end
			S_AWALK_CHK: begin
				if (!rdata[16] && {1'b0, rdata[15:0]} >= sz_q) begin
					we = 1'b1; waddr = off_q[AW+2:3];
					rsp_d.result_addr = base_q + 32'(off_q) + 32'd8;
					upd_rsp = 1'b1;
					if (rem >= OW'(24)) begin
						wdata = {1'b1, sz_q[15:0]};
						used_d = used_q + 16'(total);
						bsize_d = 16'(rem - OW'(8));
						state_d = S_AWR2;
					end else begin
						wdata = rdata | 17'h10000;
						used_d = used_q + 16'(btotal);
						state_d = S_DONE;
					end
					rsp_d.used_bytes = used_d;
				end else begin
					off_d = off_q + btotal;
					state_d = S_AWALK_RD;
				end
			end
			S_AWR2: begin
				we = 1'b1; waddr = AW'((off_q + total) >> 3); wdata = {1'b0, bsize_q};
				state_d = S_DONE;
			end
			S_ABUMP: begin
				upd_rsp = 1'b1;
				if (off_q + total > len_eff) rsp_d.status = ST_OOM;
				else begin
					we = 1'b1; waddr = off_q[AW+2:3]; wdata = {1'b1, sz_q[15:0]};
					used_d = used_q + 16'(total);
					hw_d = base_q + 32'(off_q) + 32'(total);
					rsp_d.result_addr = base_q + 32'(off_q) + 32'd8;
					rsp_d.used_bytes = used_d;
				end
				state_d = S_DONE;
			end
			S_F_RD: begin
				hoff_d = hoff_c;
				raddr = hoff_c[AW+2:3];
				if (req_q.free_addr == 32'd0 || hoff32 >= 32'(len_eff) ||
					hoff32[2:0] != 3'd0) begin
					rsp_d.status = ST_IGN; upd_rsp = 1'b1; state_d = S_DONE;
				end else state_d = S_F_CHK;
			end
			S_F_CHK: begin
				if (!rdata[16]) begin
					rsp_d.status = ST_IGN; upd_rsp = 1'b1; state_d = S_DONE;
				end else begin
					bsize_d = rdata[15:0];
					used_d = used_q - (rdata[15:0] + 16'd8);
					state_d = S_F_NRD;
				end
			end
			S_F_NRD: begin
				raddr = AW'(nxt >> 3);
				if (!hw_full && nxt < hwoff && nxt + OW'(8) <= len_eff) state_d = S_F_NCHK;
				else state_d = S_F_WRH;
			end
			S_F_NCHK: begin
				if (!rdata[16]) begin
					bsize_d = bsize_q + 16'd8 + rdata[15:0];
					we = 1'b1; waddr = AW'(nxt >> 3); wdata = '0;
				end
				state_d = S_F_WRH;
			end
			S_F_WRH: begin
				we = 1'b1; waddr = hoff_q[AW+2:3]; wdata = {1'b0, bsize_q};
				off_d = '0; have_prev_d = 1'b0; cur_d = hoff_q;
				state_d = S_F_PRD;
			end
			S_F_PRD: begin
				raddr = off_q[AW+2:3];
				if (off_q < hoff_q) state_d = S_F_PCHK;
				else if (have_prev_q) state_d = S_F_PMRG;
				else state_d = S_F_HW;
			end
			S_F_PCHK: begin
				prev_d = off_q; have_prev_d = 1'b1;
				off_d = off_q + btotal;
				state_d = S_F_PRD;
			end
			S_F_PMRG: begin
				raddr = prev_q[AW+2:3];
				state_d = S_F_HW;
			end
			S_F_HW: begin
				// rdata holds the predecessor header when one exists
				if (have_prev_q && !rdata[16]) begin
					we = 1'b1; waddr = prev_q[AW+2:3];
					wdata = {1'b0, rdata[15:0] + 16'd8 + bsize_q};
					bsize_d = rdata[15:0] + 16'd8 + bsize_q;
					cur_d = prev_q;
				end
				state_d = S_F_HWCHK;
			end
			S_F_HWCHK: begin
				if (cur_q != hoff_q) begin
					we = 1'b1; waddr = hoff_q[AW+2:3]; wdata = '0;
				end
				if (cur_q + OW'(8) + OW'(bsize_q) == hwoff) hw_d = base_q + 32'(cur_q);
				upd_rsp = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				done_d = 1'b1; state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (state_q != S_DONE && upd_rsp && rsp_d.status == ST_OK)
			rsp_d.used_bytes = used_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			base_q <= 32'h0010_0000;
			len_q <= 16'd32768;
			hw_q <= 32'h0010_0000;
			used_q <= '0;
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= done_d;
			if (cfg_we) begin
				// any register write reinitialises the heap
				if (cfg_idx == CFG_BASE) begin
					base_q <= (cfg_data + 32'd7) & ~32'd7;
					hw_q <= (cfg_data + 32'd7) & ~32'd7;
				end else begin
					len_q <= cfg_data[15:0];
					hw_q <= base_q;
				end
				used_q <= '0; clr_q <= '0; state_q <= S_CLEAR;
			end else begin
				state_q <= state_d;
				hw_q <= hw_d;
				used_q <= used_d;
				clr_q <= (state_q == S_CLEAR) ? clr_q + 1'b1 : clr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		sz_q <= sz_d; bsize_q <= bsize_d; off_q <= off_d; hoff_q <= hoff_d;
		prev_q <= prev_d; cur_q <= cur_d; have_prev_q <= have_prev_d;
		if (state_q == S_IDLE && start) req_q <= req;
		if (upd_rsp) rsp_q <= rsp_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_ign_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.result_addr == 32'd0)
		else $error("failed request with address");
	a_zero_state: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && start |=> state_q != S_IDLE)
		else $error("start not taken");
endmodule
